### hdl/sle_pkg.sv
// ---------------------------------------------------------------------------
// sle_pkg
// shared types and constants for the sorted list engine
// ---------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

    localparam int CAPACITY   = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int VAL_W      = 32;
    localparam int COUNT_OUT_W = 6;

    typedef enum logic [1:0] {
        OP_ADD_FRONT  = 2'd0,
        OP_ADD_SORTED = 2'd1,
        OP_DELETE     = 2'd2,
        OP_DUMP       = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RSVD  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_DUMP = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

endpackage

`default_nettype wire

### hdl/sorted_list_engine.sv
// ---------------------------------------------------------------------------
// sorted_list_engine
// ordered list of signed values in one memory: add at front, add sorted,
// delete all equal, dump
// ---------------------------------------------------------------------------
// insert and delete walk the stored entries once before the status transfer,
// one entry read per cycle; not every entry read is written back
// dump: one entry transfer per cycle without stalls
// the walk over the entry memory, one entry per cycle, sets the item time
// synchronous active-low reset empties the list; entries are not cleared
`default_nettype none

module sorted_list_engine
    import sle_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [1:0]              i_opcode,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [VAL_W-1:0]      o_item_value,
    output logic                         o_is_last,
    output logic [1:0]                   o_status,
    output logic [COUNT_OUT_W-1:0]       o_entry_count
);

    // entry memory
    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // control and output registers
    t_state                   r_state,   n_state;
    t_opcode                  r_op,      n_op;
    logic signed [VAL_W-1:0]  r_val,     n_val;
    logic [CNT_W-1:0]         r_count,   n_count;
    logic [CNT_W-1:0]         r_ridx,    n_ridx;
    logic [CNT_W-1:0]         r_w,       n_w;
    logic [IDX_W-1:0]         r_pidx,    n_pidx;
    logic                     r_pend,    n_pend;
    logic                     r_plast,   n_plast;
    logic                     r_ins,     n_ins;
    logic [VAL_W-1:0]         r_carry,   n_carry;
    t_status                  r_sts,     n_sts;

    logic                     r_out_valid,  n_out_valid;
    logic [VAL_W-1:0]         r_out_value,  n_out_value;
    logic                     r_out_last,   n_out_last;
    t_status                  r_out_status, n_out_status;
    logic [COUNT_OUT_W-1:0]   r_out_count,  n_out_count;

    logic out_free;
    logic in_xfer;
    logic more;

    assign out_free = !r_out_valid || i_out_ready;
    assign in_xfer  = i_in_valid && o_in_ready;
    assign more     = (r_ridx < r_count);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_val        = r_val;
        n_count      = r_count;
        n_ridx       = r_ridx;
        n_w          = r_w;
        n_pidx       = r_pidx;
        n_pend       = r_pend;
        n_plast      = r_plast;
        n_ins        = r_ins;
        n_carry      = r_carry;
        n_sts        = r_sts;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_waddr    = r_pidx;
        mem_wdata    = r_carry;
        mem_re       = 1'b0;
        mem_raddr    = r_ridx[IDX_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_op    = t_opcode'(i_opcode);
                    n_val   = i_value;
                    n_ridx  = '0;
                    n_w     = '0;
                    n_ins   = 1'b0;
                    n_pend  = 1'b0;
                    n_sts   = STS_OK;
                    if (t_opcode'(i_opcode) == OP_DUMP) begin
                        if (r_count == '0) begin
                            n_sts   = STS_EMPTY;
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_DUMP;
                        end
                    end else if (t_opcode'(i_opcode) != OP_DELETE
                                 && r_count >= CNT_W'(CAPACITY)) begin
                        n_sts   = STS_FULL;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // process the entry read last cycle
                if (r_pend) begin
                    if (r_op == OP_DELETE) begin
                        if (r_rdata != r_val) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_w[IDX_W-1:0];
                            mem_wdata = r_rdata;
                            n_w       = r_w + CNT_W'(1);
                        end
                    end else if (r_ins) begin
                        // ripple everything behind the new entry down by one
                        mem_we    = 1'b1;
                        mem_waddr = r_pidx;
                        mem_wdata = r_carry;
                        n_carry   = r_rdata;
                    end else if (r_op == OP_ADD_FRONT
                                 || $signed(r_rdata) < r_val) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_pidx;
                        mem_wdata = r_val;
                        n_carry   = r_rdata;
                        n_ins     = 1'b1;
                    end
                end
                if (more) begin
                    mem_re = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_ridx[IDX_W-1:0];
                    n_ridx = r_ridx + CNT_W'(1);
                end else begin
                    n_pend = 1'b0;
                end
                // walk finished: new count, plus the tail write for an add
                if (!r_pend && !more) begin
                    if (r_op == OP_DELETE) begin
                        n_count = r_w;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[IDX_W-1:0];
                        mem_wdata = r_ins ? r_carry : r_val;
                        n_count   = r_count + CNT_W'(1);
                    end
                    n_state = ST_DONE;
                end
            end

            ST_DUMP: begin
                if (r_pend && out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_rdata;
                    n_out_last   = r_plast;
                    n_out_status = STS_OK;
                    n_out_count  = COUNT_OUT_W'(r_count);
                    n_pend       = 1'b0;
                end
                // read data holds while a loaded result waits
                if (more && (!r_pend || out_free)) begin
                    mem_re  = 1'b1;
                    n_pend  = 1'b1;
                    n_plast = ((r_ridx + CNT_W'(1)) == r_count);
                    n_ridx  = r_ridx + CNT_W'(1);
                end
                if (!more && !r_pend) begin
                    n_state = ST_IDLE;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_last   = 1'b1;
                    n_out_status = r_sts;
                    n_out_count  = COUNT_OUT_W'(r_count);
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_val        <= n_val;
        r_ridx       <= n_ridx;
        r_w          <= n_w;
        r_pidx       <= n_pidx;
        r_plast      <= n_plast;
        r_ins        <= n_ins;
        r_carry      <= n_carry;
        r_sts        <= n_sts;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_item_value  = r_out_value;
    assign o_is_last     = r_out_last;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

    // checks

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend)
        else $error("read still pending while idle");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same entry in one cycle");

    a_count_fixed_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DUMP) && $past(r_state == ST_DUMP)) |-> $stable(r_count))
        else $error("entry count changed during dump");

endmodule

`default_nettype wire
